@@ rtl/salwc_pkg.sv @@
// shared types and constants for the lru write-back cache tag model
package salwc_pkg;

  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  localparam int RANK_W = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
  localparam int ACTIVE_W = 22;
  localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = 22'h3FFFFF;
  localparam logic [3:0] MAX_BLOCK_BITS = 4'd12;

  typedef struct packed {
    logic [1:0]  hits;
    logic        miss;
    logic        evict;
    logic        dirty_ev;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
    logic [31:0] evicted_bytes;
    logic [ACTIVE_W-1:0] active_bytes;
  } result_t;

endpackage

@@ rtl/salwc_out_reg.sv @@
// output register stage for result items
module salwc_out_reg
  import salwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    busy,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign busy       = valid_r && !out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready && !load) |=> valid_r) else $error("result dropped");
  a_data: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |=> $stable(res_r)) else $error("result changed");
`endif

endmodule

@@ rtl/set_assoc_lru_writeback_cache_sim.sv @@
// top level: set-associative lru write-back cache tag model
// Each item is one access. One row of the line memory holds every way of a set (valid,
// dirty, age rank, tag); the row is read when the item is taken and written back updated
// in the following cycle. Load and store pass once through the update logic, modify twice
// (the second pass uses the updated row, forwarded from the update logic). After reset a
// clearing pass zeroes all 2^MAX_SET_BITS rows (64 by default) and holds off the input. A
// finished result goes to an output register; the next item is taken after the update,
// while it waits there, and the input stalls otherwise only while a second result waits.
module set_assoc_lru_writeback_cache_sim
  import salwc_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // command[1:0], address[65:2], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // access_hits, access_misses, access_evictions,
                                   // dirty_evictions, total_hits, total_misses,
                                   // total_evictions, evicted_dirty_bytes,
                                   // active_dirty_bytes, zero fill
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [3:0]   cfg_data
);

  localparam int SETS  = 1 << MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W = ADDR_WIDTH - 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_UPD} state_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_t;
  typedef way_t [MAX_WAYS-1:0] row_t;

  // configuration
  logic [2:0] set_bits_r;
  logic [3:0] block_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd4;
      block_bits_r <= 4'd4;
      ways_r       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
        REG_BLOCK_BITS: block_bits_r <= cfg_data;
        REG_WAYS:       ways_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] sb, bb;
  logic [WCNT_W-1:0] nw;
  always_comb begin
    sb = {1'b0, set_bits_r};
    if (sb < 4'd1) sb = 4'd1;
    if (32'(sb) > MAX_SET_BITS) sb = 4'(MAX_SET_BITS);
    bb = block_bits_r;
    if (bb < 4'd1) bb = 4'd1;
    if (bb > MAX_BLOCK_BITS) bb = MAX_BLOCK_BITS;
    if (ways_r < 4'd1) nw = WCNT_W'(1);
    else if (32'(ways_r) > MAX_WAYS) nw = WCNT_W'(MAX_WAYS);
    else nw = WCNT_W'(ways_r);
  end

  // line memory: one row per set
  row_t line_mem [SETS];
  row_t row_rd_r;
  logic [MAX_SET_BITS-1:0] clr_r;

  // access registers
  state_t state_r;
  logic [CMD_W-1:0] cmd_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic second_r;
  logic [1:0] hits_r;
  logic miss_r, evict_r, dev_r;
  logic [31:0] th_r, tm_r, te_r, teb_r;
  logic [ACTIVE_W-1:0] act_r;
  logic done_r;

  logic [ADDR_WIDTH-1:0] addr;
  logic [ADDR_WIDTH-1:0] sh;
  logic [MAX_SET_BITS-1:0] set_in;
  logic [ADDR_WIDTH-1:0] tag_sh;
  assign addr   = in_tdata[ADDR_WIDTH+1:2];
  assign sh     = addr >> bb;
  assign set_in = sh[MAX_SET_BITS-1:0] & MAX_SET_BITS'((1 << sb) - 1);
  assign tag_sh = sh >> sb;

  logic busy, load_out, upd, last;
  result_t res;
  assign in_tready = (state_r == S_IDLE) && (!done_r || !busy);
  wire acc = in_tvalid && in_tready;
  assign upd  = (state_r == S_UPD) && (cmd_r inside {CMD_LOAD, CMD_STORE, CMD_MODIFY});
  assign last = !(cmd_r == CMD_MODIFY && !second_r);

  // update logic
  row_t row, row_n;
  logic hit, empty, is_store, dv;
  logic [WAY_W-1:0] w;
  logic [RANK_W-1:0] best, r0;
  logic [12:0] bsize;
  logic [ACTIVE_W:0] act_add;
  logic [ACTIVE_W-1:0] act_n;
  logic [31:0] teb_n;

  always_comb begin
    row = row_rd_r;
    is_store = (cmd_r == CMD_STORE) || second_r;
    bsize = 13'd1 << bb;
    hit = 1'b0; empty = 1'b0; w = '0; best = '0; dv = 1'b0;
    for (int i = MAX_WAYS-1; i >= 0; i--) begin
      if (WCNT_W'(i) < nw && row[i].valid && row[i].tag == tag_r) begin
        hit = 1'b1; w = WAY_W'(i);
      end
    end
    if (!hit) begin
      for (int i = MAX_WAYS-1; i >= 0; i--) begin
        if (WCNT_W'(i) < nw && !row[i].valid) begin
          empty = 1'b1; w = WAY_W'(i);
        end
      end
      if (!empty) begin
        w = '0;
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (WCNT_W'(i) < nw && row[i].rank > best) begin
            best = row[i].rank; w = WAY_W'(i);
          end
        end
      end
    end
    // ranks: on empty fill every other valid way ages, else ways younger than w age; ranks stop at RANK_MAX
    r0 = row[w].rank;
    row_n = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WCNT_W'(i) < nw && WAY_W'(i) != w && row[i].valid && row[i].rank < RANK_MAX &&
          (empty || row[i].rank < r0)) begin
        row_n[i].rank = row[i].rank + 1'b1;
      end
    end
    row_n[w].rank = '0;
    act_n = act_r;
    teb_n = teb_r;
    if (!hit) begin
      if (!empty && row[w].dirty) begin
        dv = 1'b1;
        teb_n = teb_r + 32'(bsize);
        act_n = (act_r > ACTIVE_W'(bsize)) ? act_r - ACTIVE_W'(bsize) : '0;
      end
      row_n[w].valid = 1'b1;
      row_n[w].dirty = 1'b0;
      row_n[w].tag   = tag_r;
    end
    act_add = {1'b0, act_n} + (ACTIVE_W+1)'(bsize);
    if (is_store && !row_n[w].dirty) begin
      row_n[w].dirty = 1'b1;
      act_n = act_add[ACTIVE_W] ? ACTIVE_MAX : act_add[ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      line_mem[clr_r] <= '0;
    end else if (upd) begin
      line_mem[set_r] <= row_n;
    end
    // second pass of a modify takes the updated row directly
    if (acc) begin
      row_rd_r <= line_mem[set_in];
    end else if (upd && !last) begin
      row_rd_r <= row_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; second_r <= 1'b0; done_r <= 1'b0;
      th_r <= '0; tm_r <= '0; te_r <= '0; teb_r <= '0; act_r <= '0;
      hits_r <= '0; miss_r <= 1'b0; evict_r <= 1'b0; dev_r <= 1'b0;
    end else begin
      if (state_r == S_UPD && last) done_r <= 1'b1;
      else if (!busy) done_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == MAX_SET_BITS'(SETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          cmd_r <= in_tdata[1:0];
          set_r <= set_in;
          tag_r <= tag_sh[TAG_W-1:0];
          second_r <= (in_tdata[1:0] == CMD_STORE);
          hits_r <= '0; miss_r <= 1'b0; evict_r <= 1'b0; dev_r <= 1'b0;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (upd) begin
            if (hit) begin hits_r <= hits_r + 2'd1; th_r <= th_r + 32'd1; end
            else begin miss_r <= 1'b1; tm_r <= tm_r + 32'd1; end
            if (!hit && !empty) begin evict_r <= 1'b1; te_r <= te_r + 32'd1; end
            if (dv) dev_r <= 1'b1;
            teb_r <= teb_n;
            act_r <= act_n;
          end
          if (!last) begin
            second_r <= 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // finished result moves to the output register once it is free
  assign load_out = done_r && !busy;

  assign res = '{hits: hits_r, miss: miss_r, evict: evict_r, dirty_ev: dev_r,
                 total_hits: th_r, total_misses: tm_r, total_evictions: te_r,
                 evicted_bytes: teb_r, active_bytes: act_r};

  result_t out_res;
  salwc_out_reg u_out (
    .clk, .rst_n, .load(load_out), .res, .busy,
    .out_tvalid, .out_tready, .out_res
  );

  assign out_tdata = {5'd0, out_res.active_bytes, out_res.evicted_bytes,
                      out_res.total_evictions, out_res.total_misses,
                      out_res.total_hits, out_res.dirty_ev, out_res.evict,
                      out_res.miss, out_res.hits};

`ifndef ASSERT_OFF
  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r != 2'd3) else $error("hit count out of range");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r != S_UPD) else $error("done overlaps update");
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && !hit && !empty) |-> row_rd_r[w].valid) else $error("evicting invalid way");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready) else $error("input taken while clearing");
`endif

endmodule
